>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the slot encoder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_ON_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_ON_CLK(label, clk, rst_n, !(cond), msg)

`endif

>>> sv/vms_pkg.sv
// ----------------------------------------------------------------------------
// Slot encoder package
// Payload structs, the byte descriptor and the slot phase codes.
// ----------------------------------------------------------------------------
package vms_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic       line_level;
        logic [1:0] slot_kind;
        logic       run_end;
    } t_out_item;

    typedef enum logic [3:0] {
        PH_PRE  = 4'b0001,
        PH_DATA = 4'b0010,
        PH_TRL  = 4'b0100,
        PH_IDLE = 4'b1000
    } t_phase;

    localparam logic [1:0] KIND_PREAMBLE = 2'd0;
    localparam logic [1:0] KIND_DATA     = 2'd1;
    localparam logic [1:0] KIND_TRAILER  = 2'd2;
    localparam logic [1:0] KIND_IDLE     = 2'd3;

    localparam logic [2:0] STRETCH_MIN = 3'd1;
    localparam logic [2:0] STRETCH_MAX = 3'd6;

    // One classified byte, with the configuration it is sent under.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic [2:0] stretch;
        logic [1:0] preamble_slots;
        logic [1:0] trailer_slots;
        t_phase     start;
    } t_desc;

endpackage

>>> sv/vms_front.sv
// ----------------------------------------------------------------------------
// Slot encoder front end
// Holds the configuration, accepts bytes and classifies them into descriptors.
// ----------------------------------------------------------------------------
module vms_front
    import vms_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [2:0] i_cfg_data,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_in_data,
    output logic       o_wr,
    input  logic       i_q_full,
    output t_desc      o_desc
);

    localparam logic [1:0] CFG_STRETCH  = 2'd0;
    localparam logic [1:0] CFG_PREAMBLE = 2'd1;
    localparam logic [1:0] CFG_TRAILER  = 2'd2;

    logic [2:0] r_stretch;
    logic [1:0] r_preamble;
    logic [1:0] r_trailer;
    logic       r_valid;
    t_desc      r_desc;
    t_desc      n_desc;
    logic       accept;

    assign o_cfg_ready = 1'b1;
    assign full        = r_valid && i_q_full;
    assign accept      = push && !full;
    assign o_wr        = r_valid && !i_q_full;
    assign o_desc      = r_desc;

    always_comb begin
        n_desc                = '0;
        n_desc.data_byte      = i_in_data.data_byte;
        n_desc.last_byte      = i_in_data.last_byte;
        n_desc.preamble_slots = r_preamble;
        n_desc.trailer_slots  = r_trailer;
        if (r_stretch < STRETCH_MIN) begin
            n_desc.stretch = STRETCH_MIN;
        end else if (r_stretch > STRETCH_MAX) begin
            n_desc.stretch = STRETCH_MAX;
        end else begin
            n_desc.stretch = r_stretch;
        end
        if (i_in_data.first_byte && (r_preamble != 2'd0)) begin
            n_desc.start = PH_PRE;
        end else begin
            n_desc.start = PH_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stretch  <= 3'd6;
            r_preamble <= 2'd3;
            r_trailer  <= 2'd3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STRETCH:  r_stretch  <= i_cfg_data;
                CFG_PREAMBLE: r_preamble <= i_cfg_data[1:0];
                CFG_TRAILER:  r_trailer  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_wr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_desc <= n_desc;
        end
    end

endmodule

>>> sv/vms_fifo.sv
// ----------------------------------------------------------------------------
// Descriptor queue
// Short first-in first-out queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vms_fifo
    import vms_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_desc i_wdata,
    output logic  o_full,
    input  logic  i_rd,
    output t_desc o_rdata,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rdata = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    `ASSERT_NEVER(a_no_write_full, i_clk, i_rst_n, i_wr && o_full, "write into full queue")
    `ASSERT_NEVER(a_no_read_empty, i_clk, i_rst_n, i_rd && o_empty, "read from empty queue")

endmodule

>>> sv/vms_back.sv
// ----------------------------------------------------------------------------
// Slot sequencer
// Expands one descriptor into preamble, Manchester data, trailer and idle slots.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vms_back
    import vms_pkg::*;
#(
    parameter int BITS_PER_CHAR = 8
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_desc     i_head,
    output logic      o_rd,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_out_data
);

    localparam logic [2:0] LAST_BIT = 3'(BITS_PER_CHAR - 1);

    logic       r_busy;
    t_phase     r_phase;
    logic [2:0] r_cnt;
    logic [2:0] r_bit;
    logic       r_half;
    t_desc      r_desc;
    logic       r_out_valid;
    t_out_item  r_out;

    t_desc      cur;
    t_phase     cur_phase;
    logic [2:0] cur_cnt;
    logic [2:0] cur_bit;
    logic       cur_half;

    t_phase     n_phase;
    logic [2:0] n_cnt;
    logic [2:0] n_bit;
    logic       n_half;
    logic       done;
    logic       coded;
    t_out_item  slot;
    logic       can_emit;
    logic       fire;

    assign can_emit   = !r_out_valid || pop;
    assign fire       = can_emit && (r_busy || !i_q_empty);
    assign o_rd       = fire && !r_busy;
    assign empty      = !r_out_valid;
    assign o_out_data = r_out;

    // An idle sequencer works straight from the queue head, so a new byte
    // follows the previous one without a bubble.
    always_comb begin
        cur       = r_busy ? r_desc : i_head;
        cur_phase = r_busy ? r_phase : i_head.start;
        cur_cnt   = r_busy ? r_cnt : 3'd0;
        cur_bit   = r_busy ? r_bit : 3'd0;
        cur_half  = r_busy && r_half;
    end

    always_comb begin
        n_phase = cur_phase;
        n_cnt   = cur_cnt + 3'd1;
        n_bit   = cur_bit;
        n_half  = cur_half;
        done    = 1'b0;
        // Inverted bit, then the second Manchester half is its complement.
        coded   = !cur.data_byte[3'd7 - cur_bit] ^ cur_half;
        slot    = '0;
        case (cur_phase)
            PH_PRE: begin
                slot.line_level = 1'b1;
                slot.slot_kind  = KIND_PREAMBLE;
                if (cur_cnt + 3'd1 == {1'b0, cur.preamble_slots}) begin
                    n_phase = PH_DATA;
                    n_cnt   = 3'd0;
                end
            end
            PH_DATA: begin
                slot.line_level = !coded;
                slot.slot_kind  = KIND_DATA;
                if (!coded || (cur_cnt + 3'd1 == cur.stretch)) begin
                    n_cnt = 3'd0;
                    if (!cur_half) begin
                        n_half = 1'b1;
                    end else begin
                        n_half = 1'b0;
                        n_bit  = cur_bit + 3'd1;
                        if (cur_bit == LAST_BIT) begin
                            n_bit = 3'd0;
                            if (!cur.last_byte) begin
                                done = 1'b1;
                            end else if (cur.trailer_slots != 2'd0) begin
                                n_phase = PH_TRL;
                            end else begin
                                n_phase = PH_IDLE;
                            end
                        end
                    end
                end
            end
            PH_TRL: begin
                slot.line_level = 1'b1;
                slot.slot_kind  = KIND_TRAILER;
                if (cur_cnt + 3'd1 == {1'b0, cur.trailer_slots}) begin
                    n_phase = PH_IDLE;
                    n_cnt   = 3'd0;
                end
            end
            PH_IDLE: begin
                slot.line_level = 1'b0;
                slot.slot_kind  = KIND_IDLE;
                done            = 1'b1;
            end
            default: begin
                slot.line_level = 1'b0;
                slot.slot_kind  = KIND_IDLE;
                done            = 1'b1;
            end
        endcase
        slot.run_end = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_phase     <= PH_DATA;
            r_cnt       <= 3'd0;
            r_bit       <= 3'd0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_busy      <= !done;
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_bit       <= n_bit;
            r_half      <= n_half;
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= slot;
        end
        if (o_rd) begin
            r_desc <= i_head;
        end
    end

    `ASSERT_NEVER(a_end_kind, i_clk, i_rst_n,
        r_out_valid && r_out.run_end &&
        (r_out.slot_kind == KIND_PREAMBLE || r_out.slot_kind == KIND_TRAILER),
        "transaction ends on a preamble or trailer slot")
    `ASSERT_ON_CLK(a_load_busy, i_clk, i_rst_n, (o_rd && !done) |=> r_busy,
        "sequencer dropped a byte after loading it")

endmodule

>>> sv/vlc_manchester_slot_encoder.sv
// ----------------------------------------------------------------------------
// Manchester slot encoder with pulse stretching
// Turns message bytes into line-level slots for a visible-light link.
// ----------------------------------------------------------------------------
// A byte is registered in the front end, then written into the queue, and
// its first slot is registered in the output register at the result port.
// Throughput: one slot per cycle while the output register is free or popped;
// a byte is BITS_PER_CHAR * (stretch + 1) slots plus its framing, at most 63.
// Reset: synchronous, active low; registers return to stretch 6, preamble 3,
// trailer 3, and all queues and the output register are emptied.
module vlc_manchester_slot_encoder
    import vms_pkg::*;
#(
    parameter int BITS_PER_CHAR = 8,
    parameter int QUEUE_DEPTH   = 2
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [2:0] i_cfg_data,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_data,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_data
);

    logic  q_wr;
    logic  q_full;
    logic  q_rd;
    logic  q_empty;
    t_desc q_wdata;
    t_desc q_rdata;

    vms_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .push        (push),
        .full        (full),
        .i_in_data   (i_in_data),
        .o_wr        (q_wr),
        .i_q_full    (q_full),
        .o_desc      (q_wdata)
    );

    vms_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    vms_back #(
        .BITS_PER_CHAR (BITS_PER_CHAR)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_head     (q_rdata),
        .o_rd       (q_rd),
        .pop        (pop),
        .empty      (empty),
        .o_out_data (o_out_data)
    );

endmodule
